// File: sv/bfc_pkg.sv
package bfc_pkg;

  localparam int MAX_PLANES_DEF = 8;

  // shared multiplier operand and product widths
  localparam int OPW  = 34;
  localparam int PRW  = 2 * OPW;

  localparam logic signed [OPW-1:0] ONE_Q16 = OPW'(65536);

  typedef enum logic [1:0] {
    OP_PLANE  = 2'd0,
    OP_MATRIX = 2'd1,
    OP_TEST   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_SPHERE = 2'd1,
    MODE_BOTH   = 2'd2,
    MODE_ALT    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    BY_NONE   = 2'd0,
    BY_SPHERE = 2'd1,
    BY_CORNER = 2'd2,
    BY_UNUSED = 2'd3
  } by_t;

  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  localparam logic [1:0] MODE_RESET  = 2'd2;
  localparam logic [3:0] COUNT_RESET = 4'd6;

endpackage

// File: sv/bfc_mul.sv
module bfc_mul (
  input  logic                            clk,
  input  logic signed [bfc_pkg::OPW-1:0]  a,
  input  logic signed [bfc_pkg::OPW-1:0]  b,
  output logic signed [bfc_pkg::PRW-1:0]  prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

// File: sv/box_frustum_cull.sv
// Iterative box cull: one shared 34x34 multiplier for every product term.
// When culling is off or no planes are used, done follows start in the next cycle;
// otherwise a sphere pass over the planes runs first, then, in mode 2 or 3, a corner
// pass that tests up to eight corners per plane.
// One box at a time: busy stays high until done; done is a one-cycle strobe.
// Reset: synchronous; mode 2, six planes, identity matrix, planes undefined.
module box_frustum_cull #(
  parameter int MAX_PLANES = bfc_pkg::MAX_PLANES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         operation,
  input  logic [3:0]         slot,
  input  logic signed [31:0] value_a,
  input  logic signed [31:0] value_b,
  input  logic signed [31:0] value_c,
  input  logic signed [31:0] value_d,
  input  logic signed [31:0] box_max_x,
  input  logic signed [31:0] box_max_y,
  input  logic signed [31:0] box_max_z,
  input  logic               wr_en,
  input  logic               wr_index,
  input  logic [3:0]         wr_data,
  output logic               done,
  output logic               culled,
  output logic [1:0]         decided_by
);

  localparam int IW  = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
  localparam int PCW = $clog2(MAX_PLANES + 1);
  localparam int CW  = (PCW > 4) ? PCW : 4;
  localparam int OPW = bfc_pkg::OPW;
  localparam int PRW = bfc_pkg::PRW;

  typedef enum logic [2:0] {
    S_IDLE, S_R2, S_XF, S_DIST, S_SQ
  } state_t;

  state_t state;
  logic   ph;
  logic   pass;
  logic [1:0] t;
  logic [1:0] k;
  logic [2:0] kc;
  logic [PCW-1:0] i;

  logic [1:0] cull_mode;
  logic [3:0] plane_count;

  logic signed [31:0] pn_x [MAX_PLANES];
  logic signed [31:0] pn_y [MAX_PLANES];
  logic signed [31:0] pn_z [MAX_PLANES];
  logic signed [31:0] p_off [MAX_PLANES];
  logic signed [31:0] mat [16];

  logic signed [31:0] lo [3];
  logic signed [31:0] hi [3];
  logic signed [31:0] c  [3];
  logic signed [32:0] h  [3];
  logic signed [31:0] w  [3];
  logic [63:0]        r2;
  logic signed [OPW-1:0] dreg;
  logic signed [PRW-1:0] acc;

  logic signed [OPW-1:0] op_a, op_b;
  logic signed [PRW-1:0] prod;
  logic signed [PRW-1:0] s_sum;
  logic signed [PRW-1:0] r2_sum;
  logic [CW-1:0]         n_planes;
  logic [IW-1:0]         pi;
  logic signed [31:0]    pt_val;
  logic signed [31:0]    pl_val;
  logic signed [32:0]    mid [3];
  logic signed [31:0]    cen [3];

  bfc_mul u_mul (
    .clk  (clk),
    .a    (op_a),
    .b    (op_b),
    .prod (prod)
  );

  assign busy = (state != S_IDLE);
  assign pi   = i[IW-1:0];

  always_comb begin
    if (CW'(plane_count) > CW'(MAX_PLANES)) begin
      n_planes = CW'(MAX_PLANES);
    end else begin
      n_planes = CW'(plane_count);
    end
  end

  // centre of the incoming box
  always_comb begin
    mid[0] = (33'(value_a) + 33'(box_max_x)) >>> 1;
    mid[1] = (33'(value_b) + 33'(box_max_y)) >>> 1;
    mid[2] = (33'(value_c) + 33'(box_max_z)) >>> 1;
    for (int j = 0; j < 3; j++) begin
      cen[j] = mid[j][31:0];
    end
  end

  // coordinate t of the current point: centre in the sphere pass, corner kc otherwise
  always_comb begin
    case (t)
      2'd0: pt_val = !pass ? c[0] : (kc[0] ? hi[0] : lo[0]);
      2'd1: pt_val = !pass ? c[1] : (kc[1] ? hi[1] : lo[1]);
      2'd2: pt_val = !pass ? c[2] : (kc[2] ? hi[2] : lo[2]);
      default: pt_val = '0;
    endcase
  end

  always_comb begin
    case (t)
      2'd0: pl_val = pn_x[pi];
      2'd1: pl_val = pn_y[pi];
      2'd2: pl_val = pn_z[pi];
      default: pl_val = p_off[pi];
    endcase
  end

  // operand select; the last term of each transform or distance sum multiplies the constant term by one
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state)
      S_R2: begin
        case (t)
          2'd0: begin op_a = OPW'(h[0]); op_b = OPW'(h[0]); end
          2'd1: begin op_a = OPW'(h[1]); op_b = OPW'(h[1]); end
          default: begin op_a = OPW'(h[2]); op_b = OPW'(h[2]); end
        endcase
      end
      S_XF: begin
        op_a = (t == 2'd3) ? bfc_pkg::ONE_Q16 : OPW'(pt_val);
        op_b = OPW'(mat[{t, k}]);
      end
      S_DIST: begin
        case (t)
          2'd0: op_a = OPW'(w[0]);
          2'd1: op_a = OPW'(w[1]);
          2'd2: op_a = OPW'(w[2]);
          default: op_a = bfc_pkg::ONE_Q16;
        endcase
        op_b = OPW'(pl_val);
      end
      S_SQ: begin
        op_a = dreg;
        op_b = dreg;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign s_sum  = acc + (prod >>> 16);
  assign r2_sum = acc + prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      ph          <= 1'b0;
      pass        <= 1'b0;
      t           <= '0;
      k           <= '0;
      kc          <= '0;
      i           <= '0;
      done        <= 1'b0;
      culled      <= 1'b0;
      decided_by  <= bfc_pkg::BY_NONE;
      cull_mode   <= bfc_pkg::MODE_RESET;
      plane_count <= bfc_pkg::COUNT_RESET;
      for (int m = 0; m < 16; m++) begin
        mat[m] <= (m % 5 == 0) ? 32'sd65536 : 32'sd0;
      end
    end else begin
      done <= 1'b0;
      if (wr_en) begin
        if (wr_index == bfc_pkg::REG_MODE) begin
          cull_mode <= wr_data[1:0];
        end else begin
          plane_count <= wr_data;
        end
      end

      case (state)
        S_IDLE: begin
          if (start) begin
            case (operation)
              bfc_pkg::OP_PLANE: begin
                if ({28'd0, slot} < MAX_PLANES) begin
                  pn_x[slot[IW-1:0]]  <= value_a;
                  pn_y[slot[IW-1:0]]  <= value_b;
                  pn_z[slot[IW-1:0]]  <= value_c;
                  p_off[slot[IW-1:0]] <= value_d;
                end
              end
              bfc_pkg::OP_MATRIX: begin
                mat[slot] <= value_a;
              end
              bfc_pkg::OP_TEST: begin
                lo[0] <= value_a;
                lo[1] <= value_b;
                lo[2] <= value_c;
                hi[0] <= box_max_x;
                hi[1] <= box_max_y;
                hi[2] <= box_max_z;
                c[0]  <= cen[0];
                c[1]  <= cen[1];
                c[2]  <= cen[2];
                h[0]  <= 33'(value_a) - 33'(cen[0]);
                h[1]  <= 33'(value_b) - 33'(cen[1]);
                h[2]  <= 33'(value_c) - 33'(cen[2]);
                if (cull_mode == bfc_pkg::MODE_OFF || n_planes == '0) begin
                  done       <= 1'b1;
                  culled     <= 1'b0;
                  decided_by <= bfc_pkg::BY_NONE;
                end else begin
                  state <= S_R2;
                  ph    <= 1'b0;
                  t     <= '0;
                  acc   <= '0;
                end
              end
              default: begin
              end
            endcase
          end
        end

        S_R2: begin
          ph <= ~ph;
          if (ph) begin
            if (t == 2'd2) begin
              r2    <= r2_sum[63:0];
              acc   <= '0;
              t     <= '0;
              k     <= '0;
              i     <= '0;
              pass  <= 1'b0;
              state <= S_XF;
            end else begin
              acc <= r2_sum;
              t   <= t + 2'd1;
            end
          end
        end

        S_XF: begin
          ph <= ~ph;
          if (ph) begin
            t <= t + 2'd1;
            if (t == 2'd3) begin
              acc <= '0;
              if (s_sum > PRW'(64'sd2147483647)) begin
                w[k] <= 32'sh7fffffff;
              end else if (s_sum < -PRW'(64'sd2147483648)) begin
                w[k] <= 32'sh80000000;
              end else begin
                w[k] <= s_sum[31:0];
              end
              if (k == 2'd2) begin
                k     <= '0;
                state <= S_DIST;
              end else begin
                k <= k + 2'd1;
              end
            end else begin
              acc <= s_sum;
            end
          end
        end

        S_DIST: begin
          ph <= ~ph;
          if (ph) begin
            t <= t + 2'd1;
            if (t == 2'd3) begin
              acc <= '0;
              if (!pass) begin
                if (s_sum > 0) begin
                  if (s_sum >= PRW'(65'sd4294967296)) begin
                    state      <= S_IDLE;
                    done       <= 1'b1;
                    culled     <= 1'b1;
                    decided_by <= bfc_pkg::BY_SPHERE;
                  end else begin
                    dreg  <= s_sum[OPW-1:0];
                    state <= S_SQ;
                  end
                end else if (CW'(i) == n_planes - CW'(1)) begin
                  if (cull_mode == bfc_pkg::MODE_SPHERE) begin
                    state      <= S_IDLE;
                    done       <= 1'b1;
                    culled     <= 1'b0;
                    decided_by <= bfc_pkg::BY_NONE;
                  end else begin
                    pass  <= 1'b1;
                    i     <= '0;
                    kc    <= '0;
                    k     <= '0;
                    state <= S_XF;
                  end
                end else begin
                  i <= i + PCW'(1);
                end
              end else begin
                if (s_sum < 0) begin
                  // a corner is inside this plane: drop to the next plane, or finish unculled after the last
                  if (CW'(i) == n_planes - CW'(1)) begin
                    state      <= S_IDLE;
                    done       <= 1'b1;
                    culled     <= 1'b0;
                    decided_by <= bfc_pkg::BY_NONE;
                  end else begin
                    i     <= i + PCW'(1);
                    kc    <= '0;
                    k     <= '0;
                    state <= S_XF;
                  end
                end else if (kc == 3'd7) begin
                  state      <= S_IDLE;
                  done       <= 1'b1;
                  culled     <= 1'b1;
                  decided_by <= bfc_pkg::BY_CORNER;
                end else begin
                  kc    <= kc + 3'd1;
                  k     <= '0;
                  state <= S_XF;
                end
              end
            end else begin
              acc <= s_sum;
            end
          end
        end

        S_SQ: begin
          ph <= ~ph;
          if (ph) begin
            if (prod > $signed({{(PRW-64){1'b0}}, r2})) begin
              state      <= S_IDLE;
              done       <= 1'b1;
              culled     <= 1'b1;
              decided_by <= bfc_pkg::BY_SPHERE;
            end else if (CW'(i) == n_planes - CW'(1)) begin
              if (cull_mode == bfc_pkg::MODE_SPHERE) begin
                state      <= S_IDLE;
                done       <= 1'b1;
                culled     <= 1'b0;
                decided_by <= bfc_pkg::BY_NONE;
              end else begin
                pass  <= 1'b1;
                i     <= '0;
                kc    <= '0;
                k     <= '0;
                state <= S_XF;
              end
            end else begin
              i     <= i + PCW'(1);
              state <= S_DIST;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
